### hdl/pbnf_pkg.sv
// Shared constants for the page bitmap next-fit allocator.
// No dependencies; imported by the allocator top level.
`timescale 1ns / 1ps
package pbnf_pkg;
    localparam int PAGES_DEFAULT = 4096;
    localparam int WORD_W        = 32;
    localparam int CFG_W         = 13;
    localparam int LEN_W         = 13;
    localparam int PAGE_W        = 12;
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
endpackage

### hdl/page_bitmap_next_fit_allocator_unit.sv
// Page bitmap next-fit allocator: bitmap memory, search sequencer, result register.
// Depends on pbnf_pkg.
`timescale 1ns / 1ps
//  channel | direction | word contents (low bit first)
//  s_      | in        | tdata: run_length[12:0], start_page[24:13]; tuser: operation
//  m_      | out       | tdata: first_page[11:0]; tuser: success
//  cfg_    | in        | cfg_wr_data: pages_in_use, written when cfg_wr_en is high
//
// After reset a clearing pass writes every bitmap word to zero, one word per cycle, and
// no word is accepted during it. An allocate fetches and scans one 32-page bitmap word
// at a time, rescanning a word after each busy page met inside it, then marks the run
// word by word with a read and a write; each read goes through the registered read port.
// A free clears the run word by word with a read and a write. Each word is accepted in
// the idle state and its result passes through the response state; a stalled output holds the latter.
// A new input word is taken once the previous result sits in the output register.
module page_bitmap_next_fit_allocator_unit #(
    parameter int PAGES = pbnf_pkg::PAGES_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [pbnf_pkg::CFG_W-1:0]  cfg_wr_data,   // pages_in_use
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,       // run_length, start_page
    input  logic                        s_tuser,       // operation
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,       // first_page
    output logic                        m_tuser        // success
);
    import pbnf_pkg::*;

    localparam int WORDS  = (PAGES + WORD_W - 1) / WORD_W;
    localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PTR_W  = $clog2(PAGES + 1);
    localparam int SUM_W  = PTR_W + 14;
    localparam int OFF_W  = $clog2(WORD_W);
    localparam int CNT_W  = OFF_W + 1;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_FETCH, ST_SCAN, ST_MRD, ST_MWR, ST_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORD_W-1:0] rdata_reg;
    logic [WA_W-1:0]   rd_addr, wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              wr_en;

    logic [CFG_W-1:0]  cfg_reg;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [LEN_W-1:0]  run_reg, run_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              op_reg, op_next;
    logic              retry_reg, retry_next;
    logic [SUM_W-1:0]  mcur_reg, mcur_next;
    logic [SUM_W-1:0]  mhi_reg, mhi_next;
    logic [WA_W:0]     clr_reg, clr_next;
    logic              res_ok_reg, res_ok_next;
    logic [PAGE_W-1:0] res_page_reg, res_page_next;
    logic              m_tvalid_reg;
    logic [PAGE_W-1:0] m_page_reg;
    logic              m_ok_reg;

    // Limit is the smaller of the configured page count and the memory size.
    logic [SUM_W-1:0] lim;
    always_comb begin
        if (SUM_W'(cfg_reg) < SUM_W'(PAGES)) begin
            lim = SUM_W'(cfg_reg);
        end else begin
            lim = SUM_W'(PAGES);
        end
    end

    // Search window within the current word.
    logic [SUM_W-1:0]  probe, probe_base, busy_abs, probe_end, wtmp_p, wtmp_m;
    logic [OFF_W-1:0]  off, busy_pos;
    logic [LEN_W-1:0]  need;
    logic [CNT_W-1:0]  room, cnt;
    logic [WORD_W-1:0] win, busy;
    logic              any_busy;

    always_comb begin
        probe      = SUM_W'(ptr_reg) + SUM_W'(run_reg);
        off        = probe[OFF_W-1:0];
        probe_base = probe - SUM_W'(off);
        need       = len_reg - run_reg;
        room       = CNT_W'(WORD_W) - CNT_W'(off);
        if (need < LEN_W'(room)) begin
            cnt = CNT_W'(need);
        end else begin
            cnt = room;
        end
        probe_end = probe + SUM_W'(cnt);
        for (int i = 0; i < WORD_W; i++) begin
            win[i] = (CNT_W'(i) >= CNT_W'(off)) && (CNT_W'(i) < CNT_W'(off) + cnt);
        end
        busy     = rdata_reg & win;
        any_busy = |busy;
        busy_pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (busy[i]) begin
                busy_pos = OFF_W'(i);
            end
        end
        busy_abs = probe_base + SUM_W'(busy_pos);
        wtmp_p   = probe >> OFF_W;
    end

    // Mark or clear window for the current word.
    logic [OFF_W-1:0]  m_off;
    logic [CNT_W-1:0]  m_room, m_cnt;
    logic [SUM_W-1:0]  m_rem;
    logic [WORD_W-1:0] m_win;
    always_comb begin
        m_off  = mcur_reg[OFF_W-1:0];
        m_room = CNT_W'(WORD_W) - CNT_W'(m_off);
        m_rem  = mhi_reg - mcur_reg;
        if (m_rem < SUM_W'(m_room)) begin
            m_cnt = CNT_W'(m_rem);
        end else begin
            m_cnt = m_room;
        end
        for (int i = 0; i < WORD_W; i++) begin
            m_win[i] = (CNT_W'(i) >= CNT_W'(m_off)) && (CNT_W'(i) < CNT_W'(m_off) + m_cnt);
        end
        wtmp_m = mcur_reg >> OFF_W;
    end

    logic [SUM_W-1:0] free_end;
    logic [SUM_W-1:0] free_hi;
    always_comb begin
        free_end = SUM_W'(s_tdata[24:13]) + SUM_W'(s_tdata[12:0]);
        free_hi  = (free_end < lim) ? free_end : lim;
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        run_next      = run_reg;
        len_next      = len_reg;
        op_next       = op_reg;
        retry_next    = retry_reg;
        mcur_next     = mcur_reg;
        mhi_next      = mhi_reg;
        clr_next      = clr_reg;
        res_ok_next   = res_ok_reg;
        res_page_next = res_page_reg;
        wr_en         = 1'b0;
        wr_addr       = wtmp_m[WA_W-1:0];
        wr_data       = '0;
        rd_addr       = wtmp_p[WA_W-1:0];
        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_reg[WA_W-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (WA_W+1)'(WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next  = s_tuser;
                    len_next = s_tdata[12:0];
                    run_next = '0;
                    retry_next = 1'b0;
                    if (s_tuser == OP_FREE) begin
                        res_ok_next   = 1'b1;
                        res_page_next = s_tdata[24:13];
                        mcur_next     = SUM_W'(s_tdata[24:13]);
                        mhi_next      = free_hi;
                        if (free_hi > SUM_W'(s_tdata[24:13])) begin
                            state_next = ST_MRD;
                        end else begin
                            state_next = ST_RESP;
                        end
                    end else if (s_tdata[12:0] == '0) begin
                        // Both passes fail at once; the pointer ends at page zero.
                        ptr_next      = '0;
                        res_ok_next   = 1'b0;
                        res_page_next = '0;
                        state_next    = ST_RESP;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (probe >= lim || (!(any_busy && busy_abs < lim) && probe_end > lim)) begin
                    run_next = '0;
                    if (!retry_reg) begin
                        ptr_next   = '0;
                        retry_next = 1'b1;
                        state_next = ST_FETCH;
                    end else begin
                        res_ok_next   = 1'b0;
                        res_page_next = '0;
                        state_next    = ST_RESP;
                    end
                end else if (any_busy) begin
                    ptr_next = PTR_W'(busy_abs + 1'b1);
                    run_next = '0;
                    if (((busy_abs + 1'b1) >> OFF_W) == wtmp_p) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end else if (run_reg + LEN_W'(cnt) == len_reg) begin
                    res_ok_next   = 1'b1;
                    res_page_next = PAGE_W'(ptr_reg);
                    mcur_next     = SUM_W'(ptr_reg);
                    mhi_next      = probe_end;
                    ptr_next      = PTR_W'(probe_end);
                    run_next      = '0;
                    state_next    = ST_MRD;
                end else begin
                    run_next   = run_reg + LEN_W'(cnt);
                    state_next = ST_FETCH;
                end
            end
            ST_MRD: begin
                rd_addr    = wtmp_m[WA_W-1:0];
                state_next = ST_MWR;
            end
            ST_MWR: begin
                rd_addr = wtmp_m[WA_W-1:0];
                wr_en   = 1'b1;
                if (op_reg == OP_FREE) begin
                    wr_data = rdata_reg & ~m_win;
                end else begin
                    wr_data = rdata_reg | m_win;
                end
                mcur_next = mcur_reg + SUM_W'(m_cnt);
                if (mcur_reg + SUM_W'(m_cnt) >= mhi_reg) begin
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_MRD;
                end
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Bitmap memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cfg_reg      <= CFG_RESET;
            ptr_reg      <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            ptr_reg <= ptr_next;
            clr_reg <= clr_next;
            if (state_reg == ST_RESP && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        run_reg      <= run_next;
        len_reg      <= len_next;
        op_reg       <= op_next;
        retry_reg    <= retry_next;
        mcur_reg     <= mcur_next;
        mhi_reg      <= mhi_next;
        res_ok_reg   <= res_ok_next;
        res_page_reg <= res_page_next;
        if (state_reg == ST_RESP && (!m_tvalid_reg || m_tready)) begin
            m_page_reg <= res_page_reg;
            m_ok_reg   <= res_ok_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_page_reg};
    assign m_tuser  = m_ok_reg;
endmodule

### hdl/pbnf_checker.sv
// Port-level checks for the page bitmap next-fit allocator, bound to its top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module pbnf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);
    // The clearing pass blocks input right after reset.
    a_clear_blocks: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input word taken during bitmap clearing");

    // Every word keeps the block busy in the cycle after it is accepted.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted word");

    // A failed allocation reports page zero.
    a_fail_page_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 16'h0000)
        else $error("failed allocation with nonzero page");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");
endmodule

bind page_bitmap_next_fit_allocator_unit pbnf_checker u_pbnf_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
